FILE: rtl/core/igs_pkg.sv
// Shared types and constants for the integer Gaussian sample generator.
`timescale 1ns / 1ps
package igs_pkg;

    localparam int U_W   = 15;
    localparam int W_W   = 30;
    localparam int K_W   = 6;
    localparam int P_W   = 31;
    localparam int R_W   = 16;
    localparam int LOG_REF = 20;
    localparam int FRAC_SHIFT = 15;

    localparam logic [P_W-1:0] P_MAX = {P_W{1'b1}};

    // Register indexes
    localparam logic REG_MEAN  = 1'b0;
    localparam logic REG_SIGMA = 1'b1;

    typedef struct packed {
        logic signed [U_W-1:0] u1;
        logic [W_W-1:0]        w;
        logic [K_W-1:0]        k;
    } t_job;

    // w >= 100*10^d means at least d+1 digits are stripped
    localparam logic [W_W-1:0] DIGIT_LIM [0:6] = '{
        30'd100, 30'd1000, 30'd10000, 30'd100000,
        30'd1000000, 30'd10000000, 30'd100000000
    };

    // floor(23*d/10)
    localparam logic [4:0] DIGIT_LN [0:7] = '{
        5'd0, 5'd2, 5'd4, 5'd6, 5'd9, 5'd11, 5'd13, 5'd16
    };

    // floor(ln_table[n]/100) steps up at n = 2, 7, 19, 54; scaled by 10^d
    localparam logic [W_W-1:0] LN_STEP [0:7][0:3] = '{
        '{30'd2,         30'd7,         30'd19,         30'd54},
        '{30'd20,        30'd70,        30'd190,        30'd540},
        '{30'd200,       30'd700,       30'd1900,       30'd5400},
        '{30'd2000,      30'd7000,      30'd19000,      30'd54000},
        '{30'd20000,     30'd70000,     30'd190000,     30'd540000},
        '{30'd200000,    30'd700000,    30'd1900000,    30'd5400000},
        '{30'd2000000,   30'd7000000,   30'd19000000,   30'd54000000},
        '{30'd20000000,  30'd70000000,  30'd190000000,  30'd540000000}
    };

endpackage

FILE: rtl/core/igs_front.sv
// Front end: centers draws, forms the squared radius, rejects and grades the log.
`timescale 1ns / 1ps
module igs_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [15:0]   i_rand_a,
    input  logic [15:0]   i_rand_b,
    output logic          o_push,
    output igs_pkg::t_job o_job,
    input  logic          i_full
);
    import igs_pkg::*;

    logic                  r_a_valid;
    logic signed [U_W-1:0] r_a_u1;
    logic signed [U_W-1:0] r_a_u2;
    logic                  r_b_valid;
    logic signed [U_W-1:0] r_b_u1;
    logic [W_W-1:0]        r_b_w;

    logic                  reject;
    logic                  b_free;
    logic                  a_free;
    logic [2:0]            digits;
    logic [2:0]            lead;
    logic [4:0]            lnw;
    logic [2*U_W-1:0]      sq1;
    logic [2*U_W-1:0]      sq2;
    logic [W_W-1:0]        n_w;

    assign reject = (r_b_w == '0) || r_b_w[W_W-1];
    assign b_free = !r_b_valid || reject || !i_full;
    assign a_free = !r_a_valid || b_free;
    assign o_ready = a_free;

    assign sq1 = 30'(r_a_u1 * r_a_u1);
    assign sq2 = 30'(r_a_u2 * r_a_u2);
    assign n_w = sq1 + sq2;

    always_comb begin
        digits = '0;
        for (int i = 0; i < 7; i++) begin
            if (r_b_w >= DIGIT_LIM[i]) begin
                digits = digits + 3'd1;
            end
        end
        lead = '0;
        for (int j = 0; j < 4; j++) begin
            if (r_b_w >= LN_STEP[digits][j]) begin
                lead = lead + 3'd1;
            end
        end
        lnw = 5'(lead) + DIGIT_LN[digits];
    end

    assign o_push   = r_b_valid && !reject && !i_full;
    assign o_job.u1 = r_b_u1;
    assign o_job.w  = r_b_w;
    assign o_job.k  = K_W'((LOG_REF - 32'(lnw)) * 2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (a_free) begin
                r_a_valid <= i_valid;
            end
            if (b_free) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_free) begin
            r_a_u1 <= {~i_rand_a[14], i_rand_a[13:0]};
            r_a_u2 <= {~i_rand_b[14], i_rand_b[13:0]};
        end
        if (b_free) begin
            r_b_u1 <= r_a_u1;
            r_b_w  <= n_w;
        end
    end

endmodule

FILE: rtl/core/igs_fifo.sv
// Two-entry queue of graded jobs between front and back.
`timescale 1ns / 1ps
module igs_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  igs_pkg::t_job i_job,
    input  logic          i_pop,
    output igs_pkg::t_job o_job,
    output logic          o_full,
    output logic          o_empty
);
    import igs_pkg::*;

    t_job       r_mem [0:1];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_job   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

endmodule

FILE: rtl/core/igs_back.sv
// Back end: divider, root, scaling multiplies and output register.
`timescale 1ns / 1ps
module igs_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  igs_pkg::t_job      i_job,
    output logic               o_pop,
    input  logic signed [31:0] i_mean,
    input  logic [15:0]        i_sigma,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_sample
);
    import igs_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_SCALE = 3'd2;
    localparam logic [2:0] S_ROOT  = 3'd3;
    localparam logic [2:0] S_MUL1  = 3'd4;
    localparam logic [2:0] S_MUL2  = 3'd5;
    localparam logic [2:0] S_SUM   = 3'd6;

    logic [2:0]            r_state;
    logic [4:0]            r_cnt;
    logic signed [U_W-1:0] r_u1;
    logic [W_W-1:0]        r_w;
    logic [K_W-1:0]        r_k;
    logic [W_W:0]          r_rem;
    logic [W_W:0]          r_quo;
    logic [P_W-1:0]        r_x;
    logic [31:0]           r_res;
    logic [P_W-1:0]        r_bit;
    logic [31:0]           r_m1;
    logic signed [47:0]    r_m2;
    logic                  r_valid;
    logic signed [31:0]    r_sample;

    logic [W_W:0]          rem_sh;
    logic                  q_bit;
    logic [K_W+W_W:0]      p_full;
    logic [31:0]           trial;
    logic signed [47:0]    m2;
    logic signed [47:0]    m2_adj;
    logic signed [32:0]    q;
    logic signed [33:0]    sum;
    logic signed [31:0]    sat;
    logic                  out_free;

    assign out_free = !r_valid || i_ready;
    assign o_pop    = (r_state == S_IDLE) && !i_empty;
    assign o_valid  = r_valid;
    assign o_sample = r_sample;

    assign rem_sh = {r_rem[W_W-1:0], (r_cnt == 5'd30)};
    assign q_bit  = (rem_sh >= {1'b0, r_w});
    assign p_full = r_k * r_quo;
    assign trial  = r_res + 32'(r_bit);
    assign m2     = $signed({1'b0, r_m1}) * r_u1;
    assign m2_adj = r_m2 + (r_m2[47] ? 48'sd32767 : 48'sd0);
    assign q      = m2_adj[47:FRAC_SHIFT];
    assign sum    = 34'(i_mean) + 34'(q);

    always_comb begin
        if (!sum[33] && (sum[32:31] != 2'b00)) begin
            sat = 32'sh7fffffff;
        end else if (sum[33] && (sum[32:31] != 2'b11)) begin
            sat = 32'sh80000000;
        end else begin
            sat = sum[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            if ((r_state == S_SUM) && out_free) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_cnt == '0) begin
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE: r_state <= S_ROOT;
                S_ROOT: begin
                    if (r_cnt == '0) begin
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: r_state <= S_MUL2;
                S_MUL2: r_state <= S_SUM;
                S_SUM: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_u1  <= i_job.u1;
                r_w   <= i_job.w;
                r_k   <= i_job.k;
                r_rem <= '0;
                r_quo <= '0;
                r_cnt <= 5'd30;
            end
            S_DIV: begin
                r_rem <= q_bit ? (rem_sh - {1'b0, r_w}) : rem_sh;
                r_quo <= {r_quo[W_W-1:0], q_bit};
                r_cnt <= r_cnt - 5'd1;
            end
            S_SCALE: begin
                r_x   <= (p_full > (K_W+W_W+1)'(P_MAX)) ? P_MAX : p_full[P_W-1:0];
                r_res <= '0;
                r_bit <= {1'b1, {(P_W-1){1'b0}}};
                r_cnt <= 5'd15;
            end
            S_ROOT: begin
                if ({1'b0, r_x} >= trial) begin
                    r_x   <= r_x - trial[P_W-1:0];
                    r_res <= (r_res >> 1) + 32'(r_bit);
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt - 5'd1;
            end
            S_MUL1: r_m1 <= i_sigma * r_res[R_W-1:0];
            S_MUL2: r_m2 <= m2;
            S_SUM: begin
                if (out_free) begin
                    r_sample <= sat;
                end
            end
            default: ;
        endcase
    end

endmodule

FILE: rtl/core/integer_gaussian_sample_generator.sv
// Integer Gaussian sample generator: register file, front, queue and back.
// The back end takes a new accepted pair only when idle; its pace is set by the 31-step divider
//   and 16-step root; rejected pairs are dropped in the front end and never queued.
// Reset: synchronous active low; clears valids, queue, sequencer, mean and sigma.
`timescale 1ns / 1ps
module integer_gaussian_sample_generator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [15:0]        i_rand_a,
    input  logic [15:0]        i_rand_b,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_sample,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import igs_pkg::*;

    logic signed [31:0] r_mean;
    logic [15:0]        r_sigma;
    logic               wr_en;
    logic               push;
    logic               pop;
    logic               full;
    logic               empty;
    t_job               front_job;
    t_job               queue_job;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_SIGMA) ? {16'b0, r_sigma} : r_mean;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean  <= '0;
            r_sigma <= '0;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_MEAN:  r_mean  <= pwdata;
                REG_SIGMA: r_sigma <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    igs_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_rand_a (i_rand_a),
        .i_rand_b (i_rand_b),
        .o_push   (push),
        .o_job    (front_job),
        .i_full   (full)
    );

    igs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (queue_job),
        .o_full  (full),
        .o_empty (empty)
    );

    igs_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (empty),
        .i_job    (queue_job),
        .o_pop    (pop),
        .i_mean   (r_mean),
        .i_sigma  (r_sigma),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_sample (o_sample)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && full)) else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(pop && empty)) else $error("queue pop while empty");

    a_job_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (front_job.w != '0) && !front_job.w[W_W-1])
        else $error("rejected radius entered queue");

endmodule
